>>> sv/rhed_pkg.sv
package rhed_pkg;

	localparam int COUNT_BITS = 32;
	localparam int LEN_BITS   = 32;
	localparam int CP_BITS    = 31;
	localparam int KW_LEN     = 8;
	localparam int KW_BITS    = $clog2(KW_LEN);

	localparam logic [7:0] MIN_LENGTH_RESET = 8'd7;
	localparam logic [CP_BITS-1:0] CP_MAX = {CP_BITS{1'b1}};

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_BRACE     = 8'h7B;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// byte order mark codes
	typedef enum logic [2:0] {
		BOM_NONE    = 3'd0,
		BOM_UTF8    = 3'd1,
		BOM_UTF16LE = 3'd2,
		BOM_UTF16BE = 3'd3,
		BOM_UTF32LE = 3'd4,
		BOM_UTF32BE = 3'd5
	} bom_kind_t;

	typedef enum logic [2:0] {
		HP_SEEK_BRACE = 3'd0,
		HP_SKIP_SPACE = 3'd1,
		HP_WANT_R     = 3'd2,
		HP_WANT_T     = 3'd3,
		HP_WANT_F     = 3'd4,
		HP_WANT_DIGIT = 3'd5,
		HP_VALID      = 3'd6,
		HP_FAILED     = 3'd7
	} header_phase_t;

	typedef enum logic [1:0] {
		NP_SEARCH      = 2'd0,
		NP_FIRST_DIGIT = 2'd1,
		NP_DIGITS      = 2'd2,
		NP_DONE        = 2'd3
	} number_phase_t;

	typedef struct packed {
		logic [CP_BITS-1:0]  code_page;
		logic                code_page_found;
		logic                header_valid;
		bom_kind_t           bom_kind;
		logic                too_short;
		logic [LEN_BITS-1:0] file_length;
	} report_t;

	// "\ansicpg"
	function automatic logic [7:0] kw_char(input logic [KW_BITS-1:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CH_BACKSLASH;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h6E;
			3'd3:    c = 8'h73;
			3'd4:    c = 8'h69;
			3'd5:    c = 8'h63;
			3'd6:    c = 8'h70;
			3'd7:    c = 8'h67;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage

>>> sv/rhed_scan.sv
module rhed_scan
	import rhed_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	input  logic           has_byte,
	input  logic           last,
	input  logic [7:0]     min_length,
	output report_t        report
);

	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [31:0]           lead_q, lead_d;
	header_phase_t         hp_q, hp_d;
	logic [KW_BITS-1:0]    kw_pos_q, kw_pos_d;
	number_phase_t         np_q, np_d;
	logic [CP_BITS-1:0]    num_q, num_d;
	logic                  ovf_q, ovf_d;

	logic [CP_BITS+3:0]    num_ext;
	logic [3:0]            digit;
	logic [63:0]           count_ext;
	logic [2:0]            lead_n;
	logic [7:0]            b0, b1, b2, b3;
	logic                  found;

	assign digit   = data_byte[3:0] - 4'd0;
	assign num_ext = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + (CP_BITS+4)'(digit);

	// next state
	always_comb begin
		count_d  = count_q;
		lead_d   = lead_q;
		hp_d     = hp_q;
		kw_pos_d = kw_pos_q;
		np_d     = np_q;
		num_d    = num_q;
		ovf_d    = ovf_q;
		if (has_byte) begin
			if (count_q < COUNT_BITS'(4)) begin
				lead_d = lead_q | (32'(data_byte) << {count_q[1:0], 3'b000});
			end
			if (count_q != {COUNT_BITS{1'b1}}) begin
				count_d = count_q + COUNT_BITS'(1);
			end

			case (hp_q)
				HP_SEEK_BRACE: begin
					if (data_byte == CH_BRACE) hp_d = HP_SKIP_SPACE;
				end
				HP_SKIP_SPACE: begin
					if (data_byte == CH_BACKSLASH) hp_d = HP_WANT_R;
					else if (!is_space(data_byte)) hp_d = HP_FAILED;
				end
				HP_WANT_R:     hp_d = (data_byte == CH_R) ? HP_WANT_T : HP_FAILED;
				HP_WANT_T:     hp_d = (data_byte == CH_T) ? HP_WANT_F : HP_FAILED;
				HP_WANT_F:     hp_d = (data_byte == CH_F) ? HP_WANT_DIGIT : HP_FAILED;
				HP_WANT_DIGIT: hp_d = is_digit(data_byte) ? HP_VALID : HP_FAILED;
				default:       hp_d = hp_q;
			endcase

			case (np_q)
				NP_SEARCH: begin
					if (data_byte == kw_char(kw_pos_q)) begin
						if (kw_pos_q == KW_BITS'(KW_LEN - 1)) begin
							np_d     = NP_FIRST_DIGIT;
							kw_pos_d = '0;
						end else begin
							kw_pos_d = kw_pos_q + KW_BITS'(1);
						end
					end else begin
						kw_pos_d = (data_byte == CH_BACKSLASH) ? KW_BITS'(1) : '0;
					end
				end
				NP_FIRST_DIGIT, NP_DIGITS: begin
					if (is_digit(data_byte)) begin
						if (num_ext > (CP_BITS+4)'(CP_MAX)) begin
							num_d = CP_MAX;
							ovf_d = 1'b1;
						end else begin
							num_d = num_ext[CP_BITS-1:0];
						end
						np_d = NP_DIGITS;
					end else begin
						if (np_q == NP_FIRST_DIGIT) ovf_d = 1'b1;
						np_d = NP_DONE;
					end
				end
				default: np_d = np_q;
			endcase
		end
	end

	// report from the state after this byte
	always_comb begin
		count_ext = 64'(count_d);
		lead_n    = (count_ext < 64'd4) ? count_ext[2:0] : 3'd4;
		b0        = lead_d[7:0];
		b1        = lead_d[15:8];
		b2        = lead_d[23:16];
		b3        = lead_d[31:24];
		found     = ((np_d == NP_DIGITS) || (np_d == NP_DONE)) && !ovf_d;

		report.file_length = (count_ext > 64'hFFFF_FFFF) ? {LEN_BITS{1'b1}}
			: count_ext[LEN_BITS-1:0];
		report.too_short = count_ext < 64'(min_length);

		if (lead_n >= 3'd4 && b0 == 8'hFF && b1 == 8'hFE && b2 == 8'h00 && b3 == 8'h00)
			report.bom_kind = BOM_UTF32LE;
		else if (lead_n >= 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE
			&& b3 == 8'hFF)
			report.bom_kind = BOM_UTF32BE;
		else if (lead_n >= 3'd3 && b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF)
			report.bom_kind = BOM_UTF8;
		else if (lead_n >= 3'd2 && b0 == 8'hFF && b1 == 8'hFE)
			report.bom_kind = BOM_UTF16LE;
		else if (lead_n >= 3'd2 && b0 == 8'hFE && b1 == 8'hFF)
			report.bom_kind = BOM_UTF16BE;
		else
			report.bom_kind = BOM_NONE;

		report.header_valid    = (hp_d == HP_VALID);
		report.code_page_found = found;
		report.code_page       = found ? num_d : '0;
	end

	// state clears after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			lead_q   <= '0;
			hp_q     <= HP_SEEK_BRACE;
			kw_pos_q <= '0;
			np_q     <= NP_SEARCH;
			num_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (step) begin
			if (last) begin
				count_q  <= '0;
				lead_q   <= '0;
				hp_q     <= HP_SEEK_BRACE;
				kw_pos_q <= '0;
				np_q     <= NP_SEARCH;
				num_q    <= '0;
				ovf_q    <= 1'b0;
			end else begin
				count_q  <= count_d;
				lead_q   <= lead_d;
				hp_q     <= hp_d;
				kw_pos_q <= kw_pos_d;
				np_q     <= np_d;
				num_q    <= num_d;
				ovf_q    <= ovf_d;
			end
		end
	end

endmodule

>>> sv/rtf_header_encoding_detect.sv
// rtf header and encoding detector: takes a file one byte per transfer on the
// slave stream (tuser marks whether the transfer carries a byte, tlast ends
// the file) and gives one report transfer on the master stream per file. the
// report holds the saturating byte count, a too-short flag against
// min_length, the byte order mark found in the leading bytes, whether the
// first '{' opens a valid "\rtf<digit>" header, and the value after the first
// "\ansicpg". one byte is taken every clock cycle except during a stall; the
// report passes from the input register through the single state update
// into the report register before it is offered on the master side. a byte
// stalls only when a finished report is still waiting on the master side and
// the next file end has reached the input register.
// min_length may only be written while no file is in flight.
module rtf_header_encoding_detect
	import rhed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // min_length
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // data_byte
	input  logic [0:0]  s_tuser,       // has_byte
	input  logic        s_tlast,       // last
	// report stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata        // file_length[31:0], too_short[32],
	                                   // bom_kind[35:33], header_valid[36],
	                                   // code_page_found[37], code_page[68:38],
	                                   // zero fill[71:69]
);

	logic       min_len_q;
	logic [7:0] min_length_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	logic       advance;
	report_t    report;
	report_t    report_q;
	logic       out_valid_q;

	assign min_len_q = cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
		end else if (min_len_q) begin
			min_length_q <= cfg_wdata;
		end
	end

	// an item leaves the input register unless it ends a file and the
	// previous report is still waiting
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			has_s1  <= s_tuser[0];
			last_s1 <= s_tlast;
		end
	end

	rhed_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.has_byte   (has_s1),
		.last       (last_s1),
		.min_length (min_length_q),
		.report     (report)
	);

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			report_q <= report;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, report_q};

endmodule
